[design/ssdw_pkg.sv]
// Shared constants, types and table-request structures for the subset-sum block.
// Depends on nothing; the interfaces, row builder, walker and top level import it.
package ssdw_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int MAX_SUM   = 1023;

  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROW_WORDS = MAX_SUM / WORD_W + 1;
  localparam int WSEL_W    = $clog2(ROW_WORDS);
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int ADDR_W    = IDX_W + WSEL_W;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 10;
  localparam int SUM_W     = 10;
  localparam int RES_IDX_W = 6;

  localparam int STEP_W    = $clog2(2 * ROW_WORDS + 1);
  localparam int LAST_STEP = 2 * ROW_WORDS;

  localparam int TOP_BITS  = MAX_SUM % WORD_W + 1;
  localparam logic [WORD_W-1:0] TOP_MASK =
    (TOP_BITS == WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TOP_BITS) - WORD_W'(1));

  // One cycle's access to the reach table.
  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } tbl_req_t;

  // One result item.
  typedef struct packed {
    logic                 found;
    logic                 has_element;
    logic [RES_IDX_W-1:0] chosen_index;
    logic [VAL_W-1:0]     chosen_value;
    logic                 overflowed;
    logic                 last_result;
  } res_t;

endpackage

[design/ssdw_if.sv]
// Valid/ready channel interfaces for set elements and for results.
// Depends on ssdw_pkg for field widths.
interface ssdw_in_if import ssdw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] element_value;
  logic             last_element;

  modport source(output valid, element_value, last_element, input ready);
  modport sink(input valid, element_value, last_element, output ready);
endinterface

interface ssdw_out_if import ssdw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 has_element;
  logic [RES_IDX_W-1:0] chosen_index;
  logic [VAL_W-1:0]     chosen_value;
  logic                 overflowed;
  logic                 last_result;

  modport source(output valid, found, has_element, chosen_index, chosen_value,
                 overflowed, last_result, input ready);
  modport sink(input valid, found, has_element, chosen_index, chosen_value,
               overflowed, last_result, output ready);
endinterface

[design/ssdw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ssdw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ssdw_fold.sv]
// Row builder: derives row r of the reach table from row r-1 and one element value.
// Depends on ssdw_pkg; drives the read and write ports of the table RAM.
module ssdw_fold import ssdw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_W-1:0]  row_in,
  input  logic [VAL_W-1:0]  value,
  input  logic [WORD_W-1:0] rdata,
  output tbl_req_t          req,
  output logic              done
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [IDX_W-1:0]    row;
  logic [WSEL_W-1:0]   ws;
  logic [BIT_W-1:0]    bs;
  logic [WORD_W-1:0]   pw;
  logic [WORD_W-1:0]   carry;

  logic                row0;
  logic [WSEL_W-1:0]   rd_word;
  logic [WSEL_W-1:0]   rsel;
  logic [WSEL_W-1:0]   wr_word;
  logic [WORD_W-1:0]   p_now;
  logic [WORD_W-1:0]   d;
  logic [2*WORD_W-1:0] joined;
  logic [WORD_W-1:0]   new_word;
  logic                wr_phase;

  // Each word takes two reads: the same word of the previous row, then the
  // word that the shift moves into it. The word below that one was read for
  // the previous word and is kept as the carry.
  always_comb begin
    row0     = (row == '0);
    rd_word  = WSEL_W'(step[STEP_W-1:1]);
    rsel     = step[0] ? (rd_word - ws) : rd_word;
    wr_word  = WSEL_W'(step[STEP_W-1:1] - 1'b1);
    wr_phase = busy && !step[0] && (step != '0);

    if (row0) begin
      p_now = {{(WORD_W-1){1'b0}}, (rd_word == '0)};
    end else begin
      p_now = rdata;
    end

    if (wr_word < ws) begin
      d = '0;
    end else if (row0) begin
      d = {{(WORD_W-1){1'b0}}, (wr_word == ws)};
    end else begin
      d = rdata;
    end

    joined   = {d, carry} << bs;
    new_word = pw | joined[2*WORD_W-1:WORD_W];
    if (wr_word == WSEL_W'(ROW_WORDS - 1)) begin
      new_word = new_word & TOP_MASK;
    end

    req.raddr = {row - 1'b1, rsel};
    req.we    = wr_phase;
    req.waddr = {row, wr_word};
    req.wdata = new_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(LAST_STEP)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row   <= row_in;
      ws    <= WSEL_W'(value[VAL_W-1:BIT_W]);
      bs    <= value[BIT_W-1:0];
      carry <= '0;
    end else if (busy) begin
      if (step[0]) begin
        pw <= p_now;
      end else if (step != '0) begin
        carry <= d;
      end
    end
  end

endmodule

[design/ssdw_trace.sv]
// Backtrack walker: checks the target and names the chosen elements, newest first.
// Depends on ssdw_pkg; reads the table RAM and the element store.
module ssdw_trace import ssdw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  count,
  input  logic [SUM_W-1:0]  target,
  input  logic              ovf,
  input  logic [WORD_W-1:0] rdata,
  input  logic [VAL_W-1:0]  evalue,
  input  logic              slot_free,
  output tbl_req_t          req,
  output logic [IDX_W-1:0]  eaddr,
  output logic              emit,
  output res_t              res,
  output logic              done
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_CHECK,
    T_FIRST,
    T_READ,
    T_DECIDE
  } tstate_t;

  tstate_t            state;
  logic [SUM_W-1:0]   s;
  logic [IDX_W-1:0]   i;
  logic               empty;
  logic               ovf_r;

  logic               hit;
  logic               reach_now;
  logic               reach_prev;
  logic [SUM_W-1:0]   s_left;
  logic [WSEL_W-1:0]  sword;

  always_comb begin
    sword      = WSEL_W'(s[SUM_W-1:BIT_W]);
    hit        = rdata[s[BIT_W-1:0]];
    reach_now  = empty ? (s == '0) : hit;
    reach_prev = (i == '0) ? 1'b0 : hit;
    s_left     = s - SUM_W'(evalue);

    req.we    = 1'b0;
    req.waddr = '0;
    req.wdata = '0;
    if (state == T_CHECK || state == T_FIRST) begin
      req.raddr = {i, sword};
    end else begin
      req.raddr = {i - 1'b1, sword};
    end
    eaddr = i;

    emit = 1'b0;
    res  = '0;
    res.overflowed = ovf_r;
    case (state)
      T_FIRST: begin
        if (!reach_now || s == '0) begin
          emit            = slot_free;
          res.found       = reach_now;
          res.last_result = 1'b1;
        end
      end
      T_DECIDE: begin
        if (!reach_prev) begin
          emit             = slot_free;
          res.found        = 1'b1;
          res.has_element  = 1'b1;
          res.chosen_index = RES_IDX_W'(i);
          res.chosen_value = evalue;
          res.last_result  = (s_left == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // The read address is held while waiting for an output slot, so the
  // registered read data stays valid across the stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            state <= T_CHECK;
          end
        end
        T_CHECK: begin
          state <= T_FIRST;
        end
        T_FIRST: begin
          if (!reach_now || s == '0) begin
            if (slot_free) begin
              state <= T_IDLE;
              done  <= 1'b1;
            end
          end else begin
            state <= T_READ;
          end
        end
        T_READ: begin
          state <= T_DECIDE;
        end
        T_DECIDE: begin
          if (reach_prev) begin
            state <= T_READ;
          end else if (slot_free) begin
            if (s_left == '0) begin
              state <= T_IDLE;
              done  <= 1'b1;
            end else begin
              state <= T_READ;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      s     <= target;
      i     <= IDX_W'(count - 1'b1);
      empty <= (count == '0);
      ovf_r <= ovf;
    end else if (state == T_DECIDE) begin
      if (reach_prev) begin
        i <= i - 1'b1;
      end else if (slot_free) begin
        s <= s_left;
        i <= i - 1'b1;
      end
    end
  end

endmodule

[design/subset_sum_dp_with_witness.sv]
// Top level of the subset-sum reachability block with witness output.
// Depends on ssdw_pkg, ssdw_if, ssdw_ram, ssdw_fold and ssdw_trace.
//
// Set elements arrive one request at a time on in_ch. Each stored element
// builds one 1024-bit row of reachable sums in a 64 x 1024 table RAM,
// held as sixteen 64-bit words per row. The row builder reads two words of
// the previous row for every word it writes, so the single read port of
// the table RAM paces each element: the builder makes two reads per word
// over sixteen words, drains the last write, raises its registered done
// flag and returns to idle before the next request is accepted. An element
// that arrives after 64 are stored is dropped and sets the overflowed flag
// of the run. After the element marked last, the backtrack walker reports
// on target_sum: one result with found low if it cannot be reached, one
// result with found high and no element if it is zero, or otherwise one
// result per chosen element in decreasing load order. For each stored row
// it visits, the walker passes through a read state and a decide state, and
// it holds while waiting on out_ch. Results pass through an output register,
// so a new element request is taken while the final result of the previous
// run still waits. target_sum must be written through cfg_write/cfg_data
// only while the block is idle; the block itself does not enforce this.
// The value is kept across runs. The table needs no clearing after reset:
// every row is written before it is read.
module subset_sum_dp_with_witness import ssdw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [SUM_W-1:0] cfg_data,
  ssdw_in_if.sink          in_ch,
  ssdw_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_TRACE
  } state_t;

  state_t           state;
  logic [SUM_W-1:0] target;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             pending_last;
  logic             out_valid;
  res_t             out_res;

  logic             accept;
  logic             room;
  logic             fold_start;
  logic             fold_done;
  logic             trace_start;
  logic             trace_done;
  logic             slot_free;
  logic             emit;
  res_t             trace_res;

  tbl_req_t          fold_req;
  tbl_req_t          trace_req;
  tbl_req_t          tbl_req;
  logic [WORD_W-1:0] tbl_rdata;
  logic [IDX_W-1:0]  eaddr;
  logic [VAL_W-1:0]  evalue;

  // Input is taken only between runs of the row builder and the walker.
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = (count < CNT_W'(MAX_ITEMS));
  assign fold_start  = accept && room;

  // The walker starts either when a dropped element carries the last mark,
  // or when the row for a last-marked element has been written.
  assign trace_start = (accept && !room && in_ch.last_element) ||
                       (state == S_FOLD && fold_done && pending_last);

  assign slot_free = !out_valid || out_ch.ready;

  assign tbl_req = (state == S_TRACE) ? trace_req : fold_req;

  ssdw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ITEMS * ROW_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (tbl_req.we),
    .waddr(tbl_req.waddr),
    .wdata(tbl_req.wdata),
    .raddr(tbl_req.raddr),
    .rdata(tbl_rdata)
  );

  // Element values, kept for the witness.
  ssdw_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ITEMS)
  ) u_elems (
    .clk  (clk),
    .we   (fold_start),
    .waddr(IDX_W'(count)),
    .wdata(in_ch.element_value),
    .raddr(eaddr),
    .rdata(evalue)
  );

  ssdw_fold u_fold (
    .clk   (clk),
    .rst   (rst),
    .start (fold_start),
    .row_in(IDX_W'(count)),
    .value (in_ch.element_value),
    .rdata (tbl_rdata),
    .req   (fold_req),
    .done  (fold_done)
  );

  // The walker sees the count and flag including this request's effect.
  ssdw_trace u_trace (
    .clk      (clk),
    .rst      (rst),
    .start    (trace_start),
    .count    ((state == S_FOLD) ? count : count),
    .target   (target),
    .ovf      ((state == S_IDLE) ? 1'b1 : ovf),
    .rdata    (tbl_rdata),
    .evalue   (evalue),
    .slot_free(slot_free),
    .req      (trace_req),
    .eaddr    (eaddr),
    .emit     (emit),
    .res      (trace_res),
    .done     (trace_done)
  );

  always_ff @(posedge clk) begin
    if (cfg_write) begin
      target <= cfg_data;
    end
    if (rst) begin
      target <= '0;
    end
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      pending_last <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              count        <= count + 1'b1;
              pending_last <= in_ch.last_element;
              state        <= S_FOLD;
            end else if (in_ch.last_element) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_TRACE;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_FOLD: begin
          if (fold_done) begin
            if (pending_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_TRACE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TRACE: begin
          if (trace_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= trace_res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.found        = out_res.found;
  assign out_ch.has_element  = out_res.has_element;
  assign out_ch.chosen_index = out_res.chosen_index;
  assign out_ch.chosen_value = out_res.chosen_value;
  assign out_ch.overflowed   = out_res.overflowed;
  assign out_ch.last_result  = out_res.last_result;

endmodule
